// ===== rtl/core/cmas_pkg.sv =====
package cmas_pkg;

  localparam int CountWidthDefault = 32;
  localparam int ClipW             = 28;
  localparam int OutW              = 32;
  localparam int OpW               = 4;
  localparam int CharW             = 8;
  localparam int QueueDepth        = 2;

  localparam logic [OpW-1:0] OpMatch    = 4'd0;
  localparam logic [OpW-1:0] OpInsert   = 4'd1;
  localparam logic [OpW-1:0] OpDelete   = 4'd2;
  localparam logic [OpW-1:0] OpSoftClip = 4'd4;

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharCaret = 8'h5E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  typedef enum logic [3:0] {
    KindMatch,
    KindInsert,
    KindDelete,
    KindClip,
    KindOtherOp,
    KindDigit,
    KindCaret,
    KindSubst,
    KindNone
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ClipW-1:0]  length;
    logic              last;
  } cmd_t;

endpackage

// ===== rtl/core/cigar_md_alignment_stats.sv =====
// Throughput: one item per cycle, sustained, while results are taken as produced.
// A record's result is registered when its final item leaves the two-entry queue
//   between classifier and accumulator and is taken by the accumulator.
// A stalled result holds the accumulator only on the next record-end item.
// Reset (rst_ni low, asynchronous): totals and clips clear, queue empties,
//   no result pending; the block is ready for items as soon as reset is released.
module cigar_md_alignment_stats #(
  parameter int CountWidth = cmas_pkg::CountWidthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [cmas_pkg::OpW-1:0]   cigar_op_i,
  input  logic [cmas_pkg::ClipW-1:0] cigar_length_i,
  input  logic [cmas_pkg::CharW-1:0] md_char_i,
  input  logic                       record_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cmas_pkg::ClipW-1:0] clip_start_o,
  output logic [cmas_pkg::ClipW-1:0] clip_end_o,
  output logic [cmas_pkg::OutW-1:0]  match_total_o,
  output logic [cmas_pkg::OutW-1:0]  insert_total_o,
  output logic [cmas_pkg::OutW-1:0]  delete_total_o,
  output logic [cmas_pkg::OutW-1:0]  substitution_total_o
);
  import cmas_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  cmas_front u_front (
    .mode_i         (mode_i),
    .cigar_op_i     (cigar_op_i),
    .cigar_length_i (cigar_length_i),
    .md_char_i      (md_char_i),
    .record_end_i   (record_end_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_o          (front_cmd),
    .cmd_valid_o    (front_valid),
    .cmd_ready_i    (front_ready)
  );

  cmas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (front_cmd),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_o  (back_cmd),
    .valid_o (back_valid),
    .ready_i (back_ready)
  );

  cmas_back #(
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (back_cmd),
    .cmd_valid_i          (back_valid),
    .cmd_ready_o          (back_ready),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .clip_start_o         (clip_start_o),
    .clip_end_o           (clip_end_o),
    .match_total_o        (match_total_o),
    .insert_total_o       (insert_total_o),
    .delete_total_o       (delete_total_o),
    .substitution_total_o (substitution_total_o)
  );

endmodule

// ===== rtl/core/cmas_front.sv =====
module cmas_front (
  input  logic                     mode_i,
  input  logic [cmas_pkg::OpW-1:0]   cigar_op_i,
  input  logic [cmas_pkg::ClipW-1:0] cigar_length_i,
  input  logic [cmas_pkg::CharW-1:0] md_char_i,
  input  logic                     record_end_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output cmas_pkg::cmd_t           cmd_o,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i
);
  import cmas_pkg::*;

  kind_e kind;

  always_comb begin
    if (!mode_i) begin
      unique case (cigar_op_i)
        OpMatch:    kind = KindMatch;
        OpInsert:   kind = KindInsert;
        OpDelete:   kind = KindDelete;
        OpSoftClip: kind = KindClip;
        default:    kind = KindOtherOp;
      endcase
    end else begin
      priority if (md_char_i == CharNul) begin
        kind = KindNone;
      end else if (md_char_i >= CharZero && md_char_i <= CharNine) begin
        kind = KindDigit;
      end else if (md_char_i == CharCaret) begin
        kind = KindCaret;
      end else begin
        kind = KindSubst;
      end
    end
  end

  assign cmd_o.kind   = kind;
  assign cmd_o.length = cigar_length_i;
  assign cmd_o.last   = record_end_i;
  assign cmd_valid_o  = in_valid_i;
  assign in_ready_o   = cmd_ready_i;

endmodule

// ===== rtl/core/cmas_queue.sv =====
module cmas_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmas_pkg::cmd_t data_i,
  input  logic           valid_i,
  output logic           ready_o,
  output cmas_pkg::cmd_t data_o,
  output logic           valid_o,
  input  logic           ready_i
);
  import cmas_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign ready_o = (count_q != CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/cmas_back.sv =====
module cmas_back #(
  parameter int CountWidth = cmas_pkg::CountWidthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmas_pkg::cmd_t             cmd_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cmas_pkg::ClipW-1:0] clip_start_o,
  output logic [cmas_pkg::ClipW-1:0] clip_end_o,
  output logic [cmas_pkg::OutW-1:0]  match_total_o,
  output logic [cmas_pkg::OutW-1:0]  insert_total_o,
  output logic [cmas_pkg::OutW-1:0]  delete_total_o,
  output logic [cmas_pkg::OutW-1:0]  substitution_total_o
);
  import cmas_pkg::*;

  localparam int SumW = ((CountWidth > ClipW) ? CountWidth : ClipW) + 1;
  localparam int ExtW = (CountWidth > OutW) ? CountWidth : OutW;
  localparam logic [SumW-1:0] TopW = {{(SumW - CountWidth){1'b0}}, {CountWidth{1'b1}}};

  function automatic logic [OutW-1:0] to_out(input logic [CountWidth-1:0] s);
    logic [ExtW-1:0] e;
    e = ExtW'(s);
    return e[OutW-1:0];
  endfunction

  logic [ClipW-1:0]      first_clip_q, first_clip_d, first_clip_n;
  logic [ClipW-1:0]      last_clip_q, last_clip_d, last_clip_n;
  logic [CountWidth-1:0] match_q, match_d, match_n;
  logic [CountWidth-1:0] insert_q, insert_d, insert_n;
  logic [CountWidth-1:0] delete_q, delete_d, delete_n;
  logic [CountWidth-1:0] subst_q, subst_d, subst_n;
  logic                  await_q, await_d, await_n;
  logic                  in_del_q, in_del_d, in_del_n;
  logic                  out_valid_q, out_valid_d;
  logic                  pop;

  logic [CountWidth-1:0] add_a;
  logic [ClipW-1:0]      add_b;
  logic [SumW-1:0]       add_raw;
  logic [CountWidth-1:0] add_sat;
  logic [ClipW-1:0]      clip;

  logic [ClipW-1:0] res_clip_start_q, res_clip_end_q;
  logic [OutW-1:0]  res_match_q, res_insert_q, res_delete_q, res_subst_q;

  assign cmd_ready_o = !cmd_i.last || !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // one shared saturating adder, at most one total accumulated per transaction
  always_comb begin
    unique case (cmd_i.kind)
      KindMatch:  add_a = match_q;
      KindInsert: add_a = insert_q;
      KindDelete: add_a = delete_q;
      default:    add_a = subst_q;
    endcase
    add_b   = (cmd_i.kind == KindSubst) ? ClipW'(1) : cmd_i.length;
    add_raw = SumW'(add_a) + SumW'(add_b);
    add_sat = (add_raw > TopW) ? TopW[CountWidth-1:0] : add_raw[CountWidth-1:0];
    clip    = (cmd_i.kind == KindClip) ? cmd_i.length : '0;
  end

  always_comb begin
    first_clip_n = first_clip_q;
    last_clip_n  = last_clip_q;
    match_n      = match_q;
    insert_n     = insert_q;
    delete_n     = delete_q;
    subst_n      = subst_q;
    await_n      = await_q;
    in_del_n     = in_del_q;
    unique case (cmd_i.kind)
      KindMatch, KindInsert, KindDelete, KindClip, KindOtherOp: begin
        if (await_q) begin
          first_clip_n = clip;
          await_n      = 1'b0;
        end
        last_clip_n = clip;
        if (cmd_i.kind == KindMatch) match_n = add_sat;
        if (cmd_i.kind == KindInsert) insert_n = add_sat;
        if (cmd_i.kind == KindDelete) delete_n = add_sat;
      end
      KindDigit: in_del_n = 1'b0;
      KindCaret: in_del_n = 1'b1;
      KindSubst: begin
        if (!in_del_q) subst_n = add_sat;
      end
      default: ;
    endcase
  end

  always_comb begin
    first_clip_d = first_clip_q;
    last_clip_d  = last_clip_q;
    match_d      = match_q;
    insert_d     = insert_q;
    delete_d     = delete_q;
    subst_d      = subst_q;
    await_d      = await_q;
    in_del_d     = in_del_q;
    if (pop) begin
      if (cmd_i.last) begin
        first_clip_d = '0;
        last_clip_d  = '0;
        match_d      = '0;
        insert_d     = '0;
        delete_d     = '0;
        subst_d      = '0;
        await_d      = 1'b1;
        in_del_d     = 1'b0;
      end else begin
        first_clip_d = first_clip_n;
        last_clip_d  = last_clip_n;
        match_d      = match_n;
        insert_d     = insert_n;
        delete_d     = delete_n;
        subst_d      = subst_n;
        await_d      = await_n;
        in_del_d     = in_del_n;
      end
    end
    if (pop && cmd_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_clip_q <= '0;
      last_clip_q  <= '0;
      match_q      <= '0;
      insert_q     <= '0;
      delete_q     <= '0;
      subst_q      <= '0;
      await_q      <= 1'b1;
      in_del_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      first_clip_q <= first_clip_d;
      last_clip_q  <= last_clip_d;
      match_q      <= match_d;
      insert_q     <= insert_d;
      delete_q     <= delete_d;
      subst_q      <= subst_d;
      await_q      <= await_d;
      in_del_q     <= in_del_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.last) begin
      res_clip_start_q <= first_clip_n;
      res_clip_end_q   <= last_clip_n;
      res_match_q      <= to_out(match_n);
      res_insert_q     <= to_out(insert_n);
      res_delete_q     <= to_out(delete_n);
      res_subst_q      <= to_out(subst_n);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign clip_start_o         = res_clip_start_q;
  assign clip_end_o           = res_clip_end_q;
  assign match_total_o        = res_match_q;
  assign insert_total_o       = res_insert_q;
  assign delete_total_o       = res_delete_q;
  assign substitution_total_o = res_subst_q;

endmodule

// ===== rtl/core/cmas_checker.sv =====
module cmas_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [cmas_pkg::ClipW-1:0] clip_start_o,
  input logic [cmas_pkg::ClipW-1:0] clip_end_o,
  input logic [cmas_pkg::OutW-1:0]  match_total_o,
  input logic [cmas_pkg::OutW-1:0]  insert_total_o,
  input logic [cmas_pkg::OutW-1:0]  delete_total_o,
  input logic [cmas_pkg::OutW-1:0]  substitution_total_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(clip_start_o) &&
      $stable(clip_end_o) && $stable(match_total_o) && $stable(insert_total_o) &&
      $stable(delete_total_o) && $stable(substitution_total_o))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result pending right after reset");

  // queue only fills behind a stalled result
  a_full_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no result pending");

  // full queue head is a record end, so draining refills the result
  a_full_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_ready_o |=> out_valid_o)
    else $error("queued record end not delivered");

endmodule

bind cigar_md_alignment_stats cmas_checker u_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cmas_pkg::*;

  localparam int CountW = CountWidthDefault;
  localparam logic ModeCigar = 1'b0;
  localparam logic ModeMd = 1'b1;
  localparam logic [CharW-1:0] CharA = 8'h41;
  localparam logic [CharW-1:0] CharC = 8'h43;
  localparam logic [CharW-1:0] CharG = 8'h47;
  localparam logic [CharW-1:0] CharT = 8'h54;
  localparam logic [CharW-1:0] CharZ = 8'h5A;
  localparam logic [CharW-1:0] CharHigh = 8'h80;
  localparam logic [CharW-1:0] CharTop = 8'hFF;
  localparam logic [OpW-1:0] OpOther = 4'd3;
  localparam logic [OpW-1:0] OpTop = 4'd15;
  localparam logic [ClipW-1:0] LenMax = '1;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic             mode;
    logic [OpW-1:0]   op;
    logic [ClipW-1:0] len;
    logic [CharW-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [ClipW-1:0] clip_start;
    logic [ClipW-1:0] clip_end;
    logic [OutW-1:0]  match_total;
    logic [OutW-1:0]  insert_total;
    logic [OutW-1:0]  delete_total;
    logic [OutW-1:0]  substitution_total;
  } totals_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             mode_i;
  logic [OpW-1:0]   cigar_op_i;
  logic [ClipW-1:0] cigar_length_i;
  logic [CharW-1:0] md_char_i;
  logic             record_end_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ClipW-1:0] clip_start_o;
  logic [ClipW-1:0] clip_end_o;
  logic [OutW-1:0]  match_total_o;
  logic [OutW-1:0]  insert_total_o;
  logic [OutW-1:0]  delete_total_o;
  logic [OutW-1:0]  substitution_total_o;

  cigar_md_alignment_stats dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .mode_i               (mode_i),
    .cigar_op_i           (cigar_op_i),
    .cigar_length_i       (cigar_length_i),
    .md_char_i            (md_char_i),
    .record_end_i         (record_end_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .clip_start_o         (clip_start_o),
    .clip_end_o           (clip_end_o),
    .match_total_o        (match_total_o),
    .insert_total_o       (insert_total_o),
    .delete_total_o       (delete_total_o),
    .substitution_total_o (substitution_total_o)
  );

  int idle_pct;
  int stall_pct;
  int items_sent;
  int error_count;
  int stuck_cycles;

  // running totals of the record in flight
  logic [ClipW-1:0]  run_first_clip;
  logic [ClipW-1:0]  run_last_clip;
  logic [CountW-1:0] run_match;
  logic [CountW-1:0] run_insert;
  logic [CountW-1:0] run_delete;
  logic [CountW-1:0] run_subst;
  logic              run_want_first;
  logic              run_in_deletion;
  totals_t           pending_totals[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [CountW-1:0] sat_sum(input logic [CountW-1:0] sum,
                                                input logic [CountW-1:0] inc);
    logic [CountW:0] wide;
    wide = {1'b0, sum} + {1'b0, inc};
    return wide[CountW] ? {CountW{1'b1}} : wide[CountW-1:0];
  endfunction

  task automatic clear_totals();
    run_first_clip  = '0;
    run_last_clip   = '0;
    run_match       = '0;
    run_insert      = '0;
    run_delete      = '0;
    run_subst       = '0;
    run_want_first  = 1'b1;
    run_in_deletion = 1'b0;
  endtask

  task automatic track_alignment_item(input logic mode, input logic [OpW-1:0] op,
                                      input logic [ClipW-1:0] len,
                                      input logic [CharW-1:0] ch, input logic last);
    logic [ClipW-1:0] clip;
    totals_t          t;
    if (mode == ModeCigar) begin
      clip = (op == OpSoftClip) ? len : '0;
      if (run_want_first) begin
        run_first_clip = clip;
        run_want_first = 1'b0;
      end
      run_last_clip = clip;
      case (op)
        OpMatch:  run_match  = sat_sum(run_match, CountW'(len));
        OpInsert: run_insert = sat_sum(run_insert, CountW'(len));
        OpDelete: run_delete = sat_sum(run_delete, CountW'(len));
        default: ;
      endcase
    end else if (ch != CharNul) begin
      if (ch >= CharZero && ch <= CharNine) begin
        run_in_deletion = 1'b0;
      end else if (!run_in_deletion) begin
        if (ch == CharCaret) run_in_deletion = 1'b1;
        else run_subst = sat_sum(run_subst, CountW'(1));
      end
    end
    if (last) begin
      t.clip_start         = run_first_clip;
      t.clip_end           = run_last_clip;
      t.match_total        = OutW'(run_match);
      t.insert_total       = OutW'(run_insert);
      t.delete_total       = OutW'(run_delete);
      t.substitution_total = OutW'(run_subst);
      pending_totals.insert(pending_totals.size(), t);
      clear_totals();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [OutW-1:0] got,
                             input logic [OutW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%08h expected 0x%08h", name, got, want));
  endtask

  always @(posedge clk_i) begin : monitor
    totals_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_totals.size() == 0) begin
          report_mismatch("result transaction with no record pending");
        end else begin
          want = pending_totals.pop_front();
          check_field("clip_start", OutW'(clip_start_o), OutW'(want.clip_start));
          check_field("clip_end", OutW'(clip_end_o), OutW'(want.clip_end));
          check_field("match_total", match_total_o, want.match_total);
          check_field("insert_total", insert_total_o, want.insert_total);
          check_field("delete_total", delete_total_o, want.delete_total);
          check_field("substitution_total", substitution_total_o,
                      want.substitution_total);
        end
      end
      if (in_valid_i && in_ready_o)
        track_alignment_item(mode_i, cigar_op_i, cigar_length_i, md_char_i, record_end_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("%0t ns  timeout: no transaction for %0d cycles", $realtime, WatchdogLimit);
        $display("** cigar_md_alignment_stats: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_item(input item_t it, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    mode_i         = it.mode;
    cigar_op_i     = it.op;
    cigar_length_i = it.len;
    md_char_i      = it.ch;
    record_end_i   = last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_record(input item_t rec[$]);
    foreach (rec[i]) send_item(rec[i], i == rec.size() - 1);
  endtask

  task automatic add_item(ref item_t rec[$], input item_t it);
    rec.insert(rec.size(), it);
  endtask

  function automatic logic [ClipW-1:0] rand_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return LenMax;
      2, 3, 4: return ClipW'($urandom());
      default: return ClipW'($urandom_range(300, 1));
    endcase
  endfunction

  function automatic item_t cigar_item(input logic [OpW-1:0] op, input logic [ClipW-1:0] len);
    item_t it;
    it.mode = ModeCigar;
    it.op   = op;
    it.len  = len;
    it.ch   = CharW'($urandom());
    return it;
  endfunction

  function automatic item_t md_item(input logic [CharW-1:0] ch);
    item_t it;
    it.mode = ModeMd;
    it.op   = OpW'($urandom());
    it.len  = ClipW'($urandom());
    it.ch   = ch;
    return it;
  endfunction

  task automatic push_md_string(ref item_t rec[$], input string s);
    for (int i = 0; i < s.len(); i++) add_item(rec, md_item(CharW'(s[i])));
  endtask

  function automatic logic [CharW-1:0] rand_letter();
    return CharW'($urandom_range(CharZ, CharA));
  endfunction

  task automatic push_md_token(ref item_t rec[$]);
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        n = $urandom_range(3, 1);
        repeat (n) add_item(rec, md_item(CharZero + CharW'($urandom_range(9))));
      end
      4, 5: begin
        case ($urandom_range(3))
          0:       add_item(rec, md_item(CharA));
          1:       add_item(rec, md_item(CharC));
          2:       add_item(rec, md_item(CharG));
          default: add_item(rec, md_item(CharT));
        endcase
      end
      6: begin
        add_item(rec, md_item(CharCaret));
        n = $urandom_range(4, 1);
        repeat (n) begin
          if ($urandom_range(7) == 0) add_item(rec, md_item(CharCaret));
          else add_item(rec, md_item(rand_letter()));
        end
      end
      7:       add_item(rec, md_item(CharW'($urandom_range(255))));
      8:       add_item(rec, md_item(CharNul));
      default: add_item(rec, md_item(rand_letter()));
    endcase
  endtask

  function automatic logic [OpW-1:0] rand_mid_op();
    case ($urandom_range(9))
      0, 1, 2, 3: return OpMatch;
      4, 5:       return OpInsert;
      6, 7:       return OpDelete;
      8:          return OpSoftClip;
      default:    return OpW'($urandom_range(15));
    endcase
  endfunction

  task automatic make_random_record(ref item_t rec[$]);
    int            pick;
    int            n;
    item_t         it;
    logic [OpW-1:0] op;
    pick = $urandom_range(99);
    if (pick < 8) begin
      n = $urandom_range(8, 1);
      repeat (n) begin
        it.mode = 1'($urandom());
        it.op   = OpW'($urandom());
        it.len  = rand_len();
        it.ch   = CharW'($urandom());
        add_item(rec, it);
      end
    end else if (pick < 14) begin
      // long runs of large lengths on one op push the totals toward saturation
      n = $urandom_range(20, 16);
      op = rand_mid_op();
      repeat (n) add_item(rec, cigar_item(op, $urandom_range(1) ? LenMax : rand_len()));
      if ($urandom_range(1)) add_item(rec, md_item(CharZero));
    end else begin
      if ($urandom_range(9) != 0) begin
        if ($urandom_range(1)) add_item(rec, cigar_item(OpSoftClip, rand_len()));
        n = $urandom_range(5);
        repeat (n) add_item(rec, cigar_item(rand_mid_op(), rand_len()));
        if ($urandom_range(1)) add_item(rec, cigar_item(OpSoftClip, rand_len()));
      end
      n = $urandom_range(6);
      repeat (n) push_md_token(rec);
    end
    if (rec.size() == 0) add_item(rec, md_item(CharNul));
  endtask

  task automatic test_cigar_ops();
    item_t rec[$];
    idle_pct  = 0;
    stall_pct = 0;
    add_item(rec, cigar_item(OpSoftClip, ClipW'(5)));
    add_item(rec, cigar_item(OpMatch, LenMax));
    add_item(rec, cigar_item(OpInsert, ClipW'(1)));
    add_item(rec, cigar_item(OpDelete, ClipW'(0)));
    add_item(rec, cigar_item(OpOther, LenMax));
    add_item(rec, cigar_item(OpTop, ClipW'(77)));
    add_item(rec, cigar_item(OpMatch, ClipW'(7)));
    add_item(rec, cigar_item(OpDelete, LenMax));
    add_item(rec, cigar_item(OpSoftClip, LenMax));
    push_md_string(rec, "3A^GC0T");
    add_item(rec, md_item(CharNul));
    add_item(rec, md_item(CharHigh));
    add_item(rec, md_item(CharTop));
    send_record(rec);
  endtask

  task automatic test_record_edges();
    item_t rec[$];
    rec = {};
    add_item(rec, cigar_item(OpSoftClip, ClipW'(9)));
    send_record(rec);
    rec = {};
    add_item(rec, cigar_item(OpOther, ClipW'(12)));
    add_item(rec, cigar_item(OpMatch, ClipW'(4)));
    add_item(rec, md_item(CharCaret));
    send_record(rec);
    rec = {};
    add_item(rec, md_item(CharA));
    send_record(rec);
    rec = {};
    push_md_string(rec, "^A^C1G");
    send_record(rec);
    rec = {};
    add_item(rec, md_item(CharNul));
    send_record(rec);
  endtask

  task automatic test_saturation();
    item_t rec[$];
    rec = {};
    repeat (16) add_item(rec, cigar_item(OpMatch, LenMax));
    add_item(rec, cigar_item(OpMatch, ClipW'(15)));
    send_record(rec);
    rec = {};
    repeat (16) add_item(rec, cigar_item(OpInsert, LenMax));
    add_item(rec, cigar_item(OpInsert, ClipW'(16)));
    add_item(rec, cigar_item(OpInsert, ClipW'(1)));
    send_record(rec);
  endtask

  task automatic test_random_records(input int idle, input int stall, input int count);
    item_t rec[$];
    int    target;
    idle_pct  = idle;
    stall_pct = stall;
    target    = items_sent + count;
    while (items_sent < target) begin
      rec = {};
      make_random_record(rec);
      send_record(rec);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = ModeCigar;
    cigar_op_i     = OpMatch;
    cigar_length_i = '0;
    md_char_i      = CharNul;
    record_end_i   = 1'b0;
    out_ready_i    = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    items_sent     = 0;
    error_count    = 0;
    stuck_cycles   = 0;
    clear_totals();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_cigar_ops();
    test_record_edges();
    test_saturation();
    test_random_records(0, 0, 115);
    test_random_records(53, 0, 115);
    test_random_records(0, 53, 115);
    test_random_records(32, 32, 115);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** cigar_md_alignment_stats: PASSED **");
    end else begin
      $display("** cigar_md_alignment_stats: FAILED **");
    end
    $finish;
  end

endmodule

// ===== cigar_md_alignment_stats.f =====
rtl/core/cmas_pkg.sv
rtl/core/cmas_front.sv
rtl/core/cmas_queue.sv
rtl/core/cmas_back.sv
rtl/core/cigar_md_alignment_stats.sv
rtl/core/cmas_checker.sv
bench/testbench.sv
